[src/heartbeat_line_parser_macros.svh]
// assertion macros for the heartbeat line parser
`ifndef HEARTBEAT_LINE_PARSER_MACROS_SVH
`define HEARTBEAT_LINE_PARSER_MACROS_SVH
`ifndef SYNTHESIS
`define HLP_ASSERT_IMPLIES(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("hlp assertion failed");
`define HLP_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("hlp assertion failed");
`else
`define HLP_ASSERT_IMPLIES(lbl, ck, rn, ante, cons)
`define HLP_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

[src/hlp_pkg.sv]
// types, constants and helper functions shared by the heartbeat line parser
package hlp_pkg;

	localparam int LINE_BUFFER = 64;
	localparam int LEN_W = $clog2(LINE_BUFFER);
	localparam logic [LEN_W-1:0] LINE_MAX = LEN_W'(LINE_BUFFER - 1);
	localparam logic [LEN_W-1:0] MIN_LINE = LEN_W'(7);

	localparam int IDLE_W = 17;
	localparam logic [IDLE_W-1:0] IDLE_MAX = '1;

	localparam int TO_W = 16;
	localparam logic [TO_W-1:0] LINE_TIMEOUT_RST = 16'd100;
	localparam logic [TO_W-1:0] LINK_TIMEOUT_RST = 16'd1000;

	localparam int CFG_IDX_W = 1;
	typedef logic [CFG_IDX_W-1:0] cfg_index_t;
	localparam cfg_index_t CFG_LINE_TIMEOUT = 1'b0;
	localparam cfg_index_t CFG_LINK_TIMEOUT = 1'b1;

	localparam logic [7:0] CH_H = 8'h48;
	localparam logic [7:0] CH_B = 8'h42;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_VT = 8'h0B;
	localparam logic [7:0] CH_FF = 8'h0C;
	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_9 = 8'h39;

	localparam logic [31:0] SAT_LIMIT = 32'd429496729;

	typedef enum logic [1:0] {
		EV_NONE    = 2'd0,
		EV_ACCEPT  = 2'd1,
		EV_DROP    = 2'd2,
		EV_TIMEOUT = 2'd3
	} hlp_event_t;

	typedef enum logic [9:0] {
		PH_H        = 10'b0000000001,
		PH_B        = 10'b0000000010,
		PH_COLON    = 10'b0000000100,
		PH_ID_PRE   = 10'b0000001000,
		PH_ID_SIGN  = 10'b0000010000,
		PH_ID_DIG   = 10'b0000100000,
		PH_SEQ_PRE  = 10'b0001000000,
		PH_SEQ_SIGN = 10'b0010000000,
		PH_SEQ_DIG  = 10'b0100000000,
		PH_FAIL     = 10'b1000000000
	} hlp_phase_t;

	typedef struct packed {
		logic       func;
		logic [7:0] byte_value;
	} hlp_req_t;

	typedef struct packed {
		hlp_event_t  event_res;
		logic [31:0] id_res;
		logic [31:0] sequence_res;
		logic [31:0] received_count;
		logic [31:0] dropped_count;
		logic        link_up;
	} hlp_res_t;

	typedef struct packed {
		logic [TO_W-1:0] line_timeout_ms;
		logic [TO_W-1:0] link_timeout_ms;
	} hlp_cfg_t;

	typedef struct packed {
		logic        ovf;
		logic [31:0] acc;
	} hlp_digit_t;

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

	// decimal accumulate, value sticks at all ones on overflow
	function automatic hlp_digit_t add_digit(input logic [31:0] acc, input logic [3:0] d);
		hlp_digit_t r;
		r.ovf = (acc > SAT_LIMIT) || ((acc == SAT_LIMIT) && (d > 4'd5));
		r.acc = r.ovf ? '1 : ({acc[28:0], 3'b000} + {acc[30:0], 1'b0} + {28'd0, d});
		return r;
	endfunction

endpackage

[src/hlp_if.sv]
// request and result channel interfaces
interface hlp_req_if;
	logic               valid;
	logic               ready;
	hlp_pkg::hlp_req_t  payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface hlp_res_if;
	logic               valid;
	logic               ready;
	hlp_pkg::hlp_res_t  payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[src/heartbeat_line_parser.sv]
// Heartbeat line parser: takes one request per clock (a serial byte or a
// millisecond tick) unless the result side stalls, and returns exactly one
// result per request; a request passes through the input register and then
// the result register, and the per-character scan with its multiply-by-ten
// accumulate sits between them. While a finished result waits, the input
// register takes at most one more request and then holds the input off until
// the result is taken. The user must write timeouts through the configuration
// port only while no request is in flight; the block does not enforce this.
`include "heartbeat_line_parser_macros.svh"
module heartbeat_line_parser (
	input  logic                clk,
	input  logic                arst_n,
	hlp_req_if.sink             req,
	hlp_res_if.source           res,
	input  logic                cfg_wr_en,
	input  hlp_pkg::cfg_index_t cfg_index,
	input  logic [15:0]         cfg_data
);
	import hlp_pkg::*;

	logic     valid_s1;
	hlp_req_t item_s1;
	logic     adv;
	hlp_cfg_t cfg_q;
	hlp_res_t result;
	logic     valid_s2;
	hlp_res_t res_s2;

	assign adv = valid_s1 && (!valid_s2 || res.ready);

	hlp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	hlp_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.line_timeout_ms <= LINE_TIMEOUT_RST;
			cfg_q.link_timeout_ms <= LINK_TIMEOUT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_LINE_TIMEOUT: cfg_q.line_timeout_ms <= cfg_data;
				CFG_LINK_TIMEOUT: cfg_q.link_timeout_ms <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (res.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= result;
		end
	end

	assign res.valid = valid_s2;
	assign res.payload = res_s2;

	`HLP_ASSERT_IMPLIES(a_stall_blocks_req, clk, arst_n, valid_s1 && !adv, !req.ready)
	`HLP_ASSERT_NEXT(a_result_after_adv, clk, arst_n, adv, valid_s2)

endmodule

[src/hlp_in_stage.sv]
// input register stage for requests
module hlp_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	hlp_req_if.sink           req,
	input  logic              adv,
	output logic              valid_s1,
	output hlp_pkg::hlp_req_t item_s1
);
	import hlp_pkg::*;

	assign req.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			item_s1 <= req.payload;
		end
	end

endmodule

[src/hlp_core.sv]
// line state, parser and counters, one request per cycle while adv is high
`include "heartbeat_line_parser_macros.svh"
module hlp_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  hlp_pkg::hlp_req_t item,
	input  hlp_pkg::hlp_cfg_t cfg,
	output hlp_pkg::hlp_res_t result
);
	import hlp_pkg::*;

	logic [LEN_W-1:0]  len_q, len_n;
	hlp_phase_t        phase_q, phase_n, p_phase;
	logic              zero_q, zero_n;
	logic [31:0]       id_acc_q, id_acc_n, p_id_acc;
	logic              id_neg_q, id_neg_n, p_id_neg;
	logic [31:0]       seq_acc_q, seq_acc_n, p_seq_acc;
	logic              seq_neg_q, seq_neg_n, p_seq_neg;
	logic [IDLE_W-1:0] line_idle_q, line_idle_n, line_idle_inc;
	logic [IDLE_W-1:0] link_idle_q, link_idle_n, link_idle_inc;
	logic              link_q, link_n;
	logic [31:0]       acc_tot_q, acc_tot_n;
	logic [31:0]       drop_tot_q, drop_tot_n;
	logic [7:0]        c;
	logic              clear;
	hlp_digit_t        id_step, seq_step;
	hlp_event_t        ev;
	logic [31:0]       sid, sq;

	assign c = item.byte_value;
	assign id_step = add_digit(id_acc_q, c[3:0]);
	assign seq_step = add_digit(seq_acc_q, c[3:0]);
	assign line_idle_inc = (line_idle_q == IDLE_MAX) ? line_idle_q : line_idle_q + 1'b1;
	assign link_idle_inc = (link_idle_q == IDLE_MAX) ? link_idle_q : link_idle_q + 1'b1;

	// one character through the prefix and number scan
	always_comb begin
		p_phase = phase_q;
		p_id_acc = id_acc_q;
		p_id_neg = id_neg_q;
		p_seq_acc = seq_acc_q;
		p_seq_neg = seq_neg_q;
		case (phase_q)
			PH_H: p_phase = (c == CH_H) ? PH_B : PH_FAIL;
			PH_B: p_phase = (c == CH_B) ? PH_COLON : PH_FAIL;
			PH_COLON: p_phase = (c == CH_COLON) ? PH_ID_PRE : PH_FAIL;
			PH_ID_PRE, PH_ID_SIGN: begin
				if ((phase_q == PH_ID_PRE) && is_blank(c)) begin
					p_phase = PH_ID_PRE;
				end else if ((phase_q == PH_ID_PRE) && ((c == CH_PLUS) || (c == CH_MINUS))) begin
					p_id_neg = (c == CH_MINUS);
					p_phase = PH_ID_SIGN;
				end else if (is_digit(c)) begin
					p_id_acc = id_step.acc;
					if (id_step.ovf) p_id_neg = 1'b0;
					p_phase = PH_ID_DIG;
				end else begin
					p_phase = PH_FAIL;
				end
			end
			PH_ID_DIG: begin
				if (is_digit(c)) begin
					p_id_acc = id_step.acc;
					if (id_step.ovf) p_id_neg = 1'b0;
				end else begin
					p_phase = (c == CH_COMMA) ? PH_SEQ_PRE : PH_FAIL;
				end
			end
			PH_SEQ_PRE, PH_SEQ_SIGN: begin
				if ((phase_q == PH_SEQ_PRE) && is_blank(c)) begin
					p_phase = PH_SEQ_PRE;
				end else if ((phase_q == PH_SEQ_PRE) && ((c == CH_PLUS) || (c == CH_MINUS))) begin
					p_seq_neg = (c == CH_MINUS);
					p_phase = PH_SEQ_SIGN;
				end else if (is_digit(c)) begin
					p_seq_acc = seq_step.acc;
					if (seq_step.ovf) p_seq_neg = 1'b0;
					p_phase = PH_SEQ_DIG;
				end else begin
					p_phase = PH_FAIL;
				end
			end
			PH_SEQ_DIG: begin
				if (is_digit(c)) begin
					p_seq_acc = seq_step.acc;
					if (seq_step.ovf) p_seq_neg = 1'b0;
				end
			end
			default: p_phase = PH_FAIL;
		endcase
	end

	always_comb begin
		len_n = len_q;
		phase_n = phase_q;
		zero_n = zero_q;
		id_acc_n = id_acc_q;
		id_neg_n = id_neg_q;
		seq_acc_n = seq_acc_q;
		seq_neg_n = seq_neg_q;
		line_idle_n = line_idle_q;
		link_idle_n = link_idle_q;
		link_n = link_q;
		acc_tot_n = acc_tot_q;
		drop_tot_n = drop_tot_q;
		clear = 1'b0;
		ev = EV_NONE;
		sid = '0;
		sq = '0;
		if (item.func) begin
			line_idle_n = line_idle_inc;
			link_idle_n = link_idle_inc;
			if ((len_q != '0) && (line_idle_inc > {1'b0, cfg.line_timeout_ms})) begin
				ev = EV_TIMEOUT;
				drop_tot_n = drop_tot_q + 32'd1;
				clear = 1'b1;
			end
			if (link_idle_inc > {1'b0, cfg.link_timeout_ms}) link_n = 1'b0;
		end else if (len_q < LINE_MAX) begin
			line_idle_n = '0;
			if ((c == CH_LF) || (c == CH_CR)) begin
				if (!(!zero_q && (len_q < MIN_LINE)) && (phase_q == PH_SEQ_DIG)) begin
					ev = EV_ACCEPT;
					sid = id_neg_q ? (32'd0 - id_acc_q) : id_acc_q;
					sq = seq_neg_q ? (32'd0 - seq_acc_q) : seq_acc_q;
					acc_tot_n = acc_tot_q + 32'd1;
					link_n = 1'b1;
					link_idle_n = '0;
				end else begin
					ev = EV_DROP;
					drop_tot_n = drop_tot_q + 32'd1;
				end
				clear = 1'b1;
			end else begin
				if (!zero_q) begin
					if (c == CH_NUL) begin
						zero_n = 1'b1;
						if (len_q < MIN_LINE) phase_n = PH_FAIL;
					end else begin
						phase_n = p_phase;
						id_acc_n = p_id_acc;
						id_neg_n = p_id_neg;
						seq_acc_n = p_seq_acc;
						seq_neg_n = p_seq_neg;
					end
				end
				len_n = len_q + 1'b1;
			end
		end
		if (clear) begin
			len_n = '0;
			phase_n = PH_H;
			zero_n = 1'b0;
			id_acc_n = '0;
			id_neg_n = 1'b0;
			seq_acc_n = '0;
			seq_neg_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			phase_q <= PH_H;
			zero_q <= 1'b0;
			id_acc_q <= '0;
			id_neg_q <= 1'b0;
			seq_acc_q <= '0;
			seq_neg_q <= 1'b0;
			line_idle_q <= '0;
			link_idle_q <= '0;
			link_q <= 1'b0;
			acc_tot_q <= '0;
			drop_tot_q <= '0;
		end else if (adv) begin
			len_q <= len_n;
			phase_q <= phase_n;
			zero_q <= zero_n;
			id_acc_q <= id_acc_n;
			id_neg_q <= id_neg_n;
			seq_acc_q <= seq_acc_n;
			seq_neg_q <= seq_neg_n;
			line_idle_q <= line_idle_n;
			link_idle_q <= link_idle_n;
			link_q <= link_n;
			acc_tot_q <= acc_tot_n;
			drop_tot_q <= drop_tot_n;
		end
	end

	always_comb begin
		result.event_res = ev;
		result.id_res = sid;
		result.sequence_res = sq;
		result.received_count = acc_tot_n;
		result.dropped_count = drop_tot_n;
		result.link_up = link_n;
	end

	`HLP_ASSERT_IMPLIES(a_len_bound, clk, arst_n, 1'b1, len_q <= LINE_MAX)
	`HLP_ASSERT_IMPLIES(a_zero_in_line, clk, arst_n, zero_q, len_q != '0)
	`HLP_ASSERT_NEXT(a_accept_count, clk, arst_n, adv && (ev == EV_ACCEPT),
		acc_tot_q == $past(acc_tot_q) + 32'd1 && link_q && (len_q == '0))
	`HLP_ASSERT_NEXT(a_drop_count, clk, arst_n, adv && ((ev == EV_DROP) || (ev == EV_TIMEOUT)),
		drop_tot_q == $past(drop_tot_q) + 32'd1 && (phase_q == PH_H))

endmodule
